[rtl/rsp_pkg.sv]
// Shared types, character codes and helper functions for the radar speed/range text parser.
// Used by rsp_scanner, rsp_out_stage and the top level; depends on nothing else.
package rsp_pkg;

  // ASCII codes the scanner reacts to.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Scan phase codes.
  localparam logic [1:0] PH_SEEK = 2'd0;
  localparam logic [1:0] PH_INT  = 2'd1;
  localparam logic [1:0] PH_FRAC = 2'd2;

  // Field index codes.
  localparam logic [1:0] FLD_SPEED = 2'd0;
  localparam logic [1:0] FLD_RANGE = 2'd1;
  localparam logic [1:0] FLD_DONE  = 2'd2;

  localparam logic [7:0] SPEED_MAX = 8'd127;

  typedef struct packed {
    logic signed [7:0] whole;
    logic [7:0]        frac;
    logic              negative;
    logic              found;
  } speed_t;

  typedef struct packed {
    logic [1:0] field;
    logic [1:0] phase;
    logic       sign;
    logic [7:0] low;
    logic       big;
    logic [3:0] frac_digit;
    speed_t     held;
  } scan_state_t;

  typedef struct packed {
    speed_t     speed;
    logic [7:0] range_value;
    logic       range_found;
  } rsp_result_t;

  // Fraction byte round(d * 25.6) for one decimal digit.
  function automatic logic [7:0] frac_byte(input logic [3:0] d);
    logic [7:0] r;
    begin
      case (d)
        4'd1:    r = 8'd26;
        4'd2:    r = 8'd51;
        4'd3:    r = 8'd77;
        4'd4:    r = 8'd102;
        4'd5:    r = 8'd128;
        4'd6:    r = 8'd154;
        4'd7:    r = 8'd179;
        4'd8:    r = 8'd205;
        4'd9:    r = 8'd230;
        default: r = 8'd0;
      endcase
      return r;
    end
  endfunction

  // Closes the number being scanned. The first number is latched as the speed.
  function automatic scan_state_t finish_number(input scan_state_t s);
    scan_state_t n;
    logic [7:0]  mag;
    begin
      n       = s;
      n.phase = PH_SEEK;
      mag     = (s.big || (s.low > SPEED_MAX)) ? SPEED_MAX : s.low;
      if (s.field == FLD_SPEED) begin
        n.held.whole    = s.sign ? (8'd0 - mag) : mag;
        n.held.frac     = frac_byte(s.frac_digit);
        n.held.negative = s.sign;
        n.held.found    = 1'b1;
        n.field         = FLD_RANGE;
      end else if (s.field == FLD_RANGE) begin
        n.field = FLD_DONE;
      end
      return n;
    end
  endfunction

endpackage

[rtl/radar_speed_range_text_parser_unit.sv]
// Top level of the radar speed/range text parser: input register, scanner, result register.
// Depends on rsp_pkg, rsp_in_stage, rsp_scanner and rsp_out_stage.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+----------------------------------------------------
//   input   | in_valid_i/in_stall_o | byte_in_i, frame_end_i
//   output  | out_valid_o/out_stall_i| speed_whole_o, speed_frac_o, speed_negative_o,
//           |                       | speed_found_o, range_value_o, range_found_o
//
// One byte is taken per cycle while in_stall_o is low. A byte waits in the input register,
// and the scan state is updated as it leaves; a byte flagged as frame end writes the frame
// result into the result register as it leaves, and out_valid_o comes from that register.
// The only stall is a frame-end byte meeting a full, stalled result register; it reaches
// in_stall_o in the same cycle. Ordinary bytes keep flowing even while a result waits.
// Reset (asynchronous, active low) clears the scan state, which is also cleared after
// every frame end.
module radar_speed_range_text_parser_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        byte_in_i,
  input  logic              frame_end_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [7:0] speed_whole_o,
  output logic [7:0]        speed_frac_o,
  output logic              speed_negative_o,
  output logic              speed_found_o,
  output logic [7:0]        range_value_o,
  output logic              range_found_o
);
  import rsp_pkg::*;

  logic        s_valid;
  logic [7:0]  s_byte;
  logic        s_end;
  logic        out_blocked;
  logic        hold;
  logic        take;
  rsp_result_t scan_result;
  rsp_result_t out_result;

  // The held byte is blocked only if it ends a frame and the result register cannot
  // take the new result in this cycle.
  assign hold = s_end && out_blocked;
  assign take = s_valid && !hold;

  rsp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .byte_in_i   (byte_in_i),
    .frame_end_i (frame_end_i),
    .hold_i      (hold),
    .valid_o     (s_valid),
    .byte_o      (s_byte),
    .end_o       (s_end)
  );

  rsp_scanner u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .byte_i   (s_byte),
    .end_i    (s_end),
    .result_o (scan_result)
  );

  rsp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && s_end),
    .result_i    (scan_result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .blocked_o   (out_blocked),
    .result_o    (out_result)
  );

  assign speed_whole_o    = out_result.speed.whole;
  assign speed_frac_o     = out_result.speed.frac;
  assign speed_negative_o = out_result.speed.negative;
  assign speed_found_o    = out_result.speed.found;
  assign range_value_o    = out_result.range_value;
  assign range_found_o    = out_result.range_found;

  // A result appears only after a frame-end byte was scanned in the cycle before.
  a_result_from_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(take && s_end))
    else $error("result offered without a scanned frame end");

  // The input side stalls only while a frame-end byte waits on the result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s_valid && s_end && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked frame end");

  // A range is only ever found after a speed.
  a_range_needs_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_found_o) |-> speed_found_o)
    else $error("range found without speed");

  // A missing speed reports all speed fields as zero.
  a_missing_speed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !speed_found_o) |->
      (speed_whole_o == 8'sd0 && speed_frac_o == 8'd0 && !speed_negative_o))
    else $error("speed fields set without a found speed");

endmodule

[rtl/rsp_in_stage.sv]
// Input register of the radar speed/range text parser: holds one accepted byte.
// Depends on no package; stall back-pressure comes from the top level.
module rsp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  input  logic       frame_end_i,
  input  logic       hold_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       end_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       end_q;
  logic       load;

  // The held byte moves on unless the scanner side is blocked.
  assign in_stall_o = valid_q && hold_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = in_stall_o ? 1'b1 : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_in_i;
      end_q  <= frame_end_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign end_o   = end_q;

endmodule

[rtl/rsp_scanner.sv]
// Per-byte scan state of the radar speed/range text parser and its update on each taken byte.
// Depends on rsp_pkg for the state types, character codes and finish_number.
module rsp_scanner (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          byte_i,
  input  logic                end_i,
  output rsp_pkg::rsp_result_t result_o
);
  import rsp_pkg::*;

  scan_state_t state_q, state_d, work;
  logic [7:0]  prev_q, prev_d;
  logic        is_digit;
  logic [3:0]  digit;
  logic [11:0] acc;

  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign digit    = 4'(byte_i - CH_ZERO);
  assign acc      = {1'b0, state_q.low, 3'b000} + {3'b000, state_q.low, 1'b0} + {8'd0, digit};

  always_comb begin
    work = state_q;
    if (state_q.field < FLD_DONE) begin
      unique case (state_q.phase)
        PH_INT: begin
          if (is_digit) begin
            if (acc > 12'd255) begin
              work.big = 1'b1;
            end
            work.low = acc[7:0];
          end else if (byte_i == CH_DOT) begin
            work.phase = PH_FRAC;
          end else begin
            work = finish_number(state_q);
          end
        end
        PH_FRAC: begin
          if (is_digit) begin
            work.frac_digit = digit;
          end
          work = finish_number(work);
        end
        default: begin
          if (is_digit) begin
            work.sign       = (prev_q == CH_MINUS);
            work.low        = {4'd0, digit};
            work.big        = 1'b0;
            work.frac_digit = 4'd0;
            work.phase      = PH_INT;
          end
        end
      endcase
    end
    // A number still open at frame end is closed with what was read.
    if (end_i && (work.phase != PH_SEEK) && (work.field < FLD_DONE)) begin
      work = finish_number(work);
    end

    result_o.speed       = work.held;
    result_o.range_found = (work.field >= FLD_DONE);
    result_o.range_value = 8'd0;
    if (result_o.range_found) begin
      result_o.range_value = work.sign ? (8'd0 - work.low) : work.low;
    end

    state_d = end_i ? '0 : work;
    prev_d  = end_i ? 8'd0 : byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      prev_q  <= 8'd0;
    end else if (take_i) begin
      state_q <= state_d;
      prev_q  <= prev_d;
    end
  end

endmodule

[rtl/rsp_out_stage.sv]
// Result register of the radar speed/range text parser: one frame result per transfer.
// Depends on rsp_pkg for the result struct.
module rsp_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  rsp_pkg::rsp_result_t result_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic                 blocked_o,
  output rsp_pkg::rsp_result_t result_o
);
  import rsp_pkg::*;

  logic        valid_q, valid_d;
  rsp_result_t result_q;

  // A new result may enter only when the register is empty or being drained.
  assign blocked_o = valid_q && out_stall_i;
  assign valid_d   = load_i ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

[sim/testbench.sv]
// Self-checking testbench for radar_speed_range_text_parser_unit: ASCII frames in, one result per frame.
// Holds a scoreboard class with its own parser prediction and uses types and codes from rsp_pkg.
`timescale 1ns / 100ps

class frame_scoreboard;
  // Prediction of the scanner state, kept at the block's widths.
  logic [1:0]      field_sel;
  logic [1:0]      phase;
  logic [7:0]      last_byte;
  logic            num_neg;
  logic [7:0]      num_low;
  logic            num_over;
  logic [3:0]      frac_dig;
  rsp_pkg::speed_t speed_latched;

  rsp_pkg::rsp_result_t frame_results[$];
  int errors;

  function new();
    errors = 0;
    restart_frame();
  endfunction

  function void restart_frame();
    field_sel     = rsp_pkg::FLD_SPEED;
    phase         = rsp_pkg::PH_SEEK;
    last_byte     = 8'h00;
    num_neg       = 1'b0;
    num_low       = 8'h00;
    num_over      = 1'b0;
    frac_dig      = 4'd0;
    speed_latched = '0;
  endfunction

  function bit is_num(logic [7:0] b);
    return (b >= rsp_pkg::CH_ZERO) && (b <= rsp_pkg::CH_NINE);
  endfunction

  // Closes the number in progress; the first one becomes the speed.
  function void close_number();
    logic [7:0] mag;
    int         frac_val;
    phase = rsp_pkg::PH_SEEK;
    if (field_sel == rsp_pkg::FLD_SPEED) begin
      mag      = (num_over || num_low > 8'd127) ? 8'd127 : num_low;
      frac_val = (int'(frac_dig) * 256 + 5) / 10;
      speed_latched.whole    = num_neg ? 8'(8'd0 - mag) : mag;
      speed_latched.frac     = 8'(frac_val);
      speed_latched.negative = num_neg;
      speed_latched.found    = 1'b1;
      field_sel = rsp_pkg::FLD_RANGE;
    end else if (field_sel == rsp_pkg::FLD_RANGE) begin
      field_sel = rsp_pkg::FLD_DONE;
    end
  endfunction

  function void scan_byte(logic [7:0] b);
    int acc;
    if (field_sel >= rsp_pkg::FLD_DONE) return;
    if (phase == rsp_pkg::PH_INT) begin
      if (is_num(b)) begin
        acc = int'(num_low) * 10 + int'(b - rsp_pkg::CH_ZERO);
        if (acc > 255) num_over = 1'b1;
        num_low = 8'(acc);
        return;
      end
      if (b == rsp_pkg::CH_DOT) begin
        phase = rsp_pkg::PH_FRAC;
        return;
      end
      close_number();
      return;
    end
    if (phase == rsp_pkg::PH_FRAC) begin
      if (is_num(b)) begin
        frac_dig = 4'(b - rsp_pkg::CH_ZERO);
        close_number();
        return;
      end
      close_number();
      if (field_sel >= rsp_pkg::FLD_DONE) return;
    end
    if (is_num(b)) begin
      num_neg  = (last_byte == rsp_pkg::CH_MINUS);
      num_low  = 8'(b - rsp_pkg::CH_ZERO);
      num_over = 1'b0;
      frac_dig = 4'd0;
      phase    = rsp_pkg::PH_INT;
    end
  endfunction

  // Called for every accepted input transfer.
  function void note_byte(logic [7:0] b, logic last);
    rsp_pkg::rsp_result_t res;
    scan_byte(b);
    last_byte = b;
    if (!last) return;
    if (phase != rsp_pkg::PH_SEEK && field_sel < rsp_pkg::FLD_DONE) close_number();
    res.speed       = speed_latched;
    res.range_found = (field_sel >= rsp_pkg::FLD_DONE);
    res.range_value = 8'h00;
    if (res.range_found) res.range_value = num_neg ? 8'(8'd0 - num_low) : num_low;
    frame_results.push_back(res);
    restart_frame();
  endfunction

  // Called for every accepted output transfer.
  function void check_result(rsp_pkg::rsp_result_t got);
    rsp_pkg::rsp_result_t exp_res;
    if (frame_results.size() == 0) begin
      $error("result transfer with no frame outstanding");
      errors++;
      return;
    end
    exp_res = frame_results.pop_front();
    if (got.speed.whole !== exp_res.speed.whole) begin
      $error("speed_whole: expected %0d, got %0d", exp_res.speed.whole, got.speed.whole);
      errors++;
    end
    if (got.speed.frac !== exp_res.speed.frac) begin
      $error("speed_frac: expected %0d, got %0d", exp_res.speed.frac, got.speed.frac);
      errors++;
    end
    if (got.speed.negative !== exp_res.speed.negative) begin
      $error("speed_negative: expected %0b, got %0b", exp_res.speed.negative,
             got.speed.negative);
      errors++;
    end
    if (got.speed.found !== exp_res.speed.found) begin
      $error("speed_found: expected %0b, got %0b", exp_res.speed.found, got.speed.found);
      errors++;
    end
    if (got.range_value !== exp_res.range_value) begin
      $error("range_value: expected %0d, got %0d", exp_res.range_value, got.range_value);
      errors++;
    end
    if (got.range_found !== exp_res.range_found) begin
      $error("range_found: expected %0b, got %0b", exp_res.range_found, got.range_found);
      errors++;
    end
  endfunction

  function int pending();
    return frame_results.size();
  endfunction
endclass

module testbench;
  import rsp_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        byte_in_i = 8'h00;
  logic              frame_end_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic signed [7:0] speed_whole_o;
  logic [7:0]        speed_frac_o;
  logic              speed_negative_o;
  logic              speed_found_o;
  logic [7:0]        range_value_o;
  logic              range_found_o;

  frame_scoreboard sb = new();

  // When set, neither side inserts gaps or stalls, so back-to-back traffic is exercised.
  bit          no_idle = 1'b0;
  int          bytes_sent = 0;
  logic [7:0]  frame_q[$];

  radar_speed_range_text_parser_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .byte_in_i        (byte_in_i),
    .frame_end_i      (frame_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .speed_whole_o    (speed_whole_o),
    .speed_frac_o     (speed_frac_o),
    .speed_negative_o (speed_negative_o),
    .speed_found_o    (speed_found_o),
    .range_value_o    (range_value_o),
    .range_found_o    (range_found_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Output monitor. Sampling at the rising edge sees the values from before the edge,
  // which is exactly what the block's registers capture for the transfer.
  always @(posedge clk_i) begin
    rsp_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.speed.whole    = speed_whole_o;
      got.speed.frac     = speed_frac_o;
      got.speed.negative = speed_negative_o;
      got.speed.found    = speed_found_o;
      got.range_value    = range_value_o;
      got.range_found    = range_found_o;
      sb.check_result(got);
    end
  end

  // Result receiver: before each result it may hold stall high at random, then it drops stall
  // and keeps it low until a result transfer has happened.
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Presents one byte after a random gap and waits for its transfer. The scoreboard is
  // told about the byte at the edge where valid was high and stall low.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    byte_in_i   <= b;
    frame_end_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endtask

  // Holds the input off until every outstanding frame result has been delivered.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Appends one decimal number with random sign, length and fraction style.
  task automatic push_number();
    int ndig;
    int frac_kind;
    if ($urandom_range(0, 1)) frame_q.push_back(CH_MINUS);
    ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
    repeat (ndig) frame_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    frac_kind = $urandom_range(0, 3);
    if (frac_kind >= 2) begin
      frame_q.push_back(CH_DOT);
      frame_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end else if (frac_kind == 1) begin
      frame_q.push_back(CH_DOT);
    end
  endtask

  // Separator text between numbers: unit strings, or an arbitrary byte now and then.
  task automatic push_gap_text();
    case ($urandom_range(0, 3))
      0:       push_text(" m/s ");
      1:       push_text(" ");
      2:       push_text(",");
      default: frame_q.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  // Builds one random frame: mostly well-formed speed/range text, sometimes noise,
  // truncated frames or extra numbers after the range.
  task automatic build_random_frame();
    int kind;
    int cut;
    kind = $urandom_range(0, 9);
    if (kind == 7) begin
      repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    push_number();
    if (kind != 6) begin
      push_gap_text();
      push_number();
      if ($urandom_range(0, 1)) push_text(" m");
      if (kind == 9) begin
        push_gap_text();
        push_number();
      end
    end
    if (kind == 8) begin
      cut = $urandom_range(0, frame_q.size() - 1);
      frame_q = frame_q[0:cut];
    end
  endtask

  initial begin
    int frame_no;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames. A lone digit is positive at frame start and still open at the
    // end; the second frame has a negative speed with fraction and a negative range
    // beyond one byte; the third saturates a negative speed and ends it at a bare dot.
    push_text("7");
    send_frame();
    push_text("-9.5-300");
    send_frame();
    push_text("-999.x1");
    send_frame();
    // Bytes after the range are ignored; zero and all-ones bytes act as separators.
    frame_q = '{8'h31, 8'h00, 8'h32, 8'hFF, 8'h33};
    send_frame();
    // A frame with no number at all.
    frame_q = '{8'hFF};
    send_frame();
    drain_results();

    // Random frames, with stretches of back-to-back traffic and an occasional full drain.
    frame_no = 0;
    while (bytes_sent < 1750) begin
      no_idle = ((frame_no / 20) % 3) == 2;
      build_random_frame();
      send_frame();
      frame_no++;
      if (frame_no % 50 == 0) drain_results();
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run of the stimulus above.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
rtl/rsp_pkg.sv
rtl/rsp_in_stage.sv
rtl/rsp_scanner.sv
rtl/rsp_out_stage.sv
rtl/radar_speed_range_text_parser_unit.sv
sim/testbench.sv
